### rtl/lab_pkg.sv
// Package with the shared types, constants and lookup tables of the sRGB to L*a*b* converter.
package lab_pkg;

  localparam int STAGES = 8;
  localparam int CH_W   = 8;
  localparam int LIN_W  = 17;
  localparam int COEF_W = 20;
  localparam int PROD_W = COEF_W + LIN_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int XYZ_W  = 17;
  localparam int F_W    = 17;
  localparam int NUM_W  = 26;
  localparam int RCP_W  = 27;
  localparam int RCP_SH = 38;
  localparam int RAW_W  = 28;
  localparam int L_W    = 15;
  localparam int AB_W   = 16;

  localparam logic [XYZ_W-1:0] XYZ_MAX = 17'd131071;

  // Largest normalised value that still takes the linear segment of f().
  localparam longint unsigned LIN_LIMIT_L = (64'd216 * 64'd65536) / 64'd24389;
  localparam logic [XYZ_W-1:0] LIN_LIMIT  = XYZ_W'(LIN_LIMIT_L);
  localparam logic [14:0] LIN_MUL = 15'd24389;
  localparam logic [NUM_W-1:0] LIN_OFS = 26'd28313118;
  // Reciprocal of 3132 for an exact quotient of any 26-bit numerator.
  localparam longint unsigned RCP_L = ((64'd1 << RCP_SH) + 64'd3131) / 64'd3132;
  localparam logic [RCP_W-1:0] LIN_RCP = RCP_W'(RCP_L);

  localparam longint unsigned WX2 = 64'd1928442000;
  localparam longint unsigned WY2 = 64'd2000000000;
  localparam longint unsigned WZ2 = 64'd1650422000;

  localparam longint unsigned M00 = ((64'd436052025 << 21) + WX2 / 2) / WX2;
  localparam longint unsigned M01 = ((64'd385081593 << 21) + WX2 / 2) / WX2;
  localparam longint unsigned M02 = ((64'd143087414 << 21) + WX2 / 2) / WX2;
  localparam longint unsigned M10 = ((64'd222491598 << 21) + WY2 / 2) / WY2;
  localparam longint unsigned M11 = ((64'd716886060 << 21) + WY2 / 2) / WY2;
  localparam longint unsigned M12 = ((64'd60621486 << 21) + WY2 / 2) / WY2;
  localparam longint unsigned M20 = ((64'd13929122 << 21) + WZ2 / 2) / WZ2;
  localparam longint unsigned M21 = ((64'd97097002 << 21) + WZ2 / 2) / WZ2;
  localparam longint unsigned M22 = ((64'd714185470 << 21) + WZ2 / 2) / WZ2;

  typedef logic [COEF_W-1:0] coef_t [3][3];
  localparam coef_t MTX = '{
    '{COEF_W'(M00), COEF_W'(M01), COEF_W'(M02)},
    '{COEF_W'(M10), COEF_W'(M11), COEF_W'(M12)},
    '{COEF_W'(M20), COEF_W'(M21), COEF_W'(M22)}
  };

  typedef logic [2:0][XYZ_W-1:0] xyz_vec_t;
  typedef logic [LIN_W-1:0] lin_rom_t [256];
  typedef logic [F_W-1:0] cbrt_rom_t [513];

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    longint unsigned n;
    longint unsigned t;
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p2;
    longint unsigned p4;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        rom[c] = LIN_W'((longint'(c) * 64'd13107200 + 64'd329460) / 64'd658920);
      end else begin
        n = 64'd1000 * longint'(c) + 64'd14025;
        t = ((n << 31) + 64'd134512) / 64'd269025;
        s = (t * t + (64'd1 << 29)) >> 30;
        lo = 0;
        hi = 64'd1 << 24;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          p2 = (mid * mid) >> 24;
          p4 = (p2 * p2) >> 24;
          if (((p4 * mid) >> 16) <= s) lo = mid;
          else hi = mid - 1;
        end
        rom[c] = LIN_W'((s * lo + (64'd1 << 39)) >> 40);
      end
    end
    return rom;
  endfunction

  function automatic cbrt_rom_t build_cbrt_rom();
    cbrt_rom_t rom;
    longint unsigned n;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned h;
    for (int i = 0; i <= 512; i++) begin
      n = longint'(i) << 40;
      lo = 0;
      hi = 64'd1 << 17;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid <= n) lo = mid;
        else hi = mid - 1;
      end
      h = 2 * lo + 1;
      if (h * h * h <= 8 * n) lo = lo + 1;
      rom[i] = F_W'(lo);
    end
    return rom;
  endfunction

  localparam lin_rom_t  LIN_ROM  = build_lin_rom();
  localparam cbrt_rom_t CBRT_ROM = build_cbrt_rom();

endpackage

### rtl/lab_if.sv
// Stream interfaces for the sRGB pixel input and the L*a*b* result output.
interface lab_in_if;
  logic                       valid;
  logic                       ready;
  logic [lab_pkg::CH_W-1:0]   red;
  logic [lab_pkg::CH_W-1:0]   green;
  logic [lab_pkg::CH_W-1:0]   blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface lab_out_if;
  logic                             valid;
  logic                             ready;
  logic [lab_pkg::L_W-1:0]          lightness;
  logic signed [lab_pkg::AB_W-1:0]  green_red_axis;
  logic signed [lab_pkg::AB_W-1:0]  blue_yellow_axis;
  modport source (output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink (input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface

### rtl/lab_lin.sv
// Linearisation table and 3x3 matrix stages giving white-normalised XYZ.
module lab_lin (
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  logic [lab_pkg::CH_W-1:0]    red,
  input  logic [lab_pkg::CH_W-1:0]    green,
  input  logic [lab_pkg::CH_W-1:0]    blue,
  output lab_pkg::xyz_vec_t           xyz
);
  import lab_pkg::*;

  logic [LIN_W-1:0]  lin  [3];
  logic [PROD_W-1:0] prod [3][3];
  logic [ACC_W-1:0]  acc  [3];
  logic [ACC_W-21:0] rnd  [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lin[0] <= LIN_ROM[red];
      lin[1] <= LIN_ROM[green];
      lin[2] <= LIN_ROM[blue];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(MTX[i][j] * lin[j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2])
             + ACC_W'(20'h80000);
      rnd[i] = acc[i][ACC_W-1:20];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        xyz[i] <= (rnd[i] > (ACC_W-20)'(XYZ_MAX)) ? XYZ_MAX : XYZ_W'(rnd[i]);
      end
    end
  end

endmodule

### rtl/lab_fn.sv
// Three-stage Lab f() unit: linear segment by reciprocal, cube root by table interpolation.
module lab_fn (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  logic [lab_pkg::XYZ_W-1:0]  v,
  output logic [lab_pkg::F_W-1:0]    f
);
  import lab_pkg::*;

  logic                   is_lin_a;
  logic [NUM_W-1:0]       num_a;
  logic [XYZ_W-1:0]       m_a;
  logic [1:0]             e_a;
  logic [XYZ_W-1:0]       m_c;
  logic [1:0]             e_c;

  logic                       is_lin_b;
  logic [NUM_W+RCP_W-1:0]     quot_prod;
  logic [F_W-1:0]             ca;
  logic [F_W-1:0]             cb;
  logic [7:0]                 fr;
  logic [1:0]                 e_b;
  logic [8:0]                 idx;

  logic [F_W-1:0]   diff;
  logic [F_W+7:0]   step;
  logic [F_W-1:0]   g;
  logic [F_W-1:0]   g_sh;
  logic [F_W-1:0]   quot;

  // Scale small values by eight, at most three times, towards the top range of the table.
  always_comb begin
    if (v >= 17'd16384) begin
      e_c = 2'd0;
      m_c = v;
    end else if (v >= 17'd2048) begin
      e_c = 2'd1;
      m_c = v << 3;
    end else if (v >= 17'd256) begin
      e_c = 2'd2;
      m_c = v << 6;
    end else begin
      e_c = 2'd3;
      m_c = v << 9;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      is_lin_a <= (v <= LIN_LIMIT);
      num_a    <= NUM_W'(LIN_MUL * v[9:0]) + LIN_OFS;
      m_a      <= m_c;
      e_a      <= e_c;
    end
  end

  assign idx = m_a[16:8];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      is_lin_b  <= is_lin_a;
      quot_prod <= num_a * LIN_RCP;
      ca        <= CBRT_ROM[{1'b0, idx}];
      cb        <= CBRT_ROM[10'({1'b0, idx}) + 10'd1];
      fr        <= m_a[7:0];
      e_b       <= e_a;
    end
  end

  always_comb begin
    diff = cb - ca;
    step = ((F_W+8)'(diff * fr) + (F_W+8)'(128)) >> 8;
    g    = ca + F_W'(step);
    unique case (e_b)
      2'd0: g_sh = g;
      2'd1: g_sh = F_W'((18'(g) + 18'd1) >> 1);
      2'd2: g_sh = F_W'((18'(g) + 18'd2) >> 2);
      2'd3: g_sh = F_W'((18'(g) + 18'd4) >> 3);
      default: g_sh = g;
    endcase
    quot = F_W'(quot_prod[NUM_W+RCP_W-1:RCP_SH]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      f <= is_lin_b ? quot : g_sh;
    end
  end

endmodule

### rtl/lab_out.sv
// Output stages forming L*, a* and b* from the f() values, with rounding and saturation.
module lab_out (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic [lab_pkg::F_W-1:0]           fx,
  input  logic [lab_pkg::F_W-1:0]           fy,
  input  logic [lab_pkg::F_W-1:0]           fz,
  output logic [lab_pkg::L_W-1:0]           lightness,
  output logic signed [lab_pkg::AB_W-1:0]   green_red_axis,
  output logic signed [lab_pkg::AB_W-1:0]   blue_yellow_axis
);
  import lab_pkg::*;

  logic signed [RAW_W-1:0] sx;
  logic signed [RAW_W-1:0] sy;
  logic signed [RAW_W-1:0] sz;
  logic signed [RAW_W-1:0] l_raw;
  logic signed [RAW_W-1:0] a_raw;
  logic signed [RAW_W-1:0] b_raw;
  logic signed [RAW_W-9:0] l_r;
  logic signed [RAW_W-9:0] a_r;
  logic signed [RAW_W-9:0] b_r;

  always_comb begin
    sx = $signed(RAW_W'(fx));
    sy = $signed(RAW_W'(fy));
    sz = $signed(RAW_W'(fz));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l_raw <= RAW_W'(28'sd116 * sy - 28'sd1048576);
      a_raw <= RAW_W'(28'sd500 * (sx - sy));
      b_raw <= RAW_W'(28'sd200 * (sy - sz));
    end
  end

  // Rounding is half towards plus infinity, an arithmetic shift after adding half.
  always_comb begin
    l_r = (RAW_W-8)'((l_raw + 28'sd128) >>> 8);
    a_r = (RAW_W-8)'((a_raw + 28'sd128) >>> 8);
    b_r = (RAW_W-8)'((b_raw + 28'sd128) >>> 8);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (l_r < 0) lightness <= '0;
      else if (l_r > 20'sd25600) lightness <= 15'd25600;
      else lightness <= L_W'(l_r);
      if (a_r < -20'sd32768) green_red_axis <= 16'sh8000;
      else if (a_r > 20'sd32767) green_red_axis <= 16'sh7FFF;
      else green_red_axis <= AB_W'(a_r);
      if (b_r < -20'sd32768) blue_yellow_axis <= 16'sh8000;
      else if (b_r > 20'sd32767) blue_yellow_axis <= 16'sh7FFF;
      else blue_yellow_axis <= AB_W'(b_r);
    end
  end

endmodule

### rtl/srgb_to_cielab_d50.sv
// Top level of the sRGB to CIE L*a*b* (D50) converter.
// Throughput is one pixel per cycle unless lab_out.ready stalls the eight stages.
// Each stage holds its transaction until the next stage has room, so bubbles are squeezed out.
// Synchronous reset clears the stage valid bits only; data registers are not reset.
module srgb_to_cielab_d50 (
  input  logic       clk,
  input  logic       rst,
  lab_in_if.sink     pix_in,
  lab_out_if.source  lab_out
);
  import lab_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;
  xyz_vec_t          xyz;
  logic [F_W-1:0]    fv [3];

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || lab_out.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pix_in.valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign pix_in.ready  = en[0];
  assign lab_out.valid = vld[STAGES-1];

  lab_lin u_lin (
    .clk   (clk),
    .en    (en[2:0]),
    .red   (pix_in.red),
    .green (pix_in.green),
    .blue  (pix_in.blue),
    .xyz   (xyz)
  );

  for (genvar i = 0; i < 3; i++) begin : g_fn
    lab_fn u_fn (
      .clk (clk),
      .en  (en[5:3]),
      .v   (xyz[i]),
      .f   (fv[i])
    );
  end

  lab_out u_out (
    .clk              (clk),
    .en               (en[7:6]),
    .fx               (fv[0]),
    .fy               (fv[1]),
    .fz               (fv[2]),
    .lightness        (lab_out.lightness),
    .green_red_axis   (lab_out.green_red_axis),
    .blue_yellow_axis (lab_out.blue_yellow_axis)
  );

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> vld[0])
    else $error("accepted pixel did not reach the first stage");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (&vld))
    else $error("input stalled while the pipeline had a free stage");

  a_lightness_range: assert property (@(posedge clk) disable iff (rst)
    lab_out.valid |-> (lab_out.lightness <= 15'd25600))
    else $error("lightness beyond saturation limit");

  a_mid_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !en[3]) |=> vld[3])
    else $error("stalled transaction lost in the middle of the pipeline");

endmodule

### test/tb.sv
// Self-checking testbench for the sRGB to CIE L*a*b* (D50) converter.

class lab_scoreboard;
  typedef struct {
    logic [lab_pkg::L_W-1:0]  lightness;
    logic [lab_pkg::AB_W-1:0] green_red_axis;
    logic [lab_pkg::AB_W-1:0] blue_yellow_axis;
  } lab_result_t;

  lab_result_t      pending_lab[$];
  int               fail_count;
  longint unsigned  gamma_lut[256];
  longint unsigned  root_lut[513];
  longint unsigned  coef[3][3];

  function new();
    longint unsigned num, den, t, s, lo, hi, mid, p2, p4, h;
    longint unsigned mnum[3][3];
    longint unsigned wden[3];
    mnum = '{'{436052025, 385081593, 143087414},
             '{222491598, 716886060, 60621486},
             '{13929122, 97097002, 714185470}};
    wden = '{964221000, 1000000000, 825211000};
    fail_count = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        coef[i][j] = ((mnum[i][j] << 21) + wden[i]) / (2 * wden[i]);
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        gamma_lut[c] = (longint'(c) * 13107200 + 329460) / 658920;
      end else begin
        num = 1000 * longint'(c) + 14025;
        den = 269025;
        t = ((num << 31) + den / 2) / den;
        s = (t * t + (64'd1 << 29)) >> 30;
        lo = 0;
        hi = 64'd1 << 24;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          p2 = (mid * mid) >> 24;
          p4 = (p2 * p2) >> 24;
          if (((p4 * mid) >> 16) <= s) lo = mid;
          else hi = mid - 1;
        end
        gamma_lut[c] = (s * lo + (64'd1 << 39)) >> 40;
      end
    end
    for (int i = 0; i <= 512; i++) begin
      num = longint'(i) << 40;
      lo = 0;
      hi = 64'd1 << 17;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid <= num) lo = mid;
        else hi = mid - 1;
      end
      h = 2 * lo + 1;
      if (h * h * h <= 8 * num) lo++;
      root_lut[i] = lo;
    end
  endfunction

  function longint unsigned lab_curve(longint unsigned v);
    int unsigned e;
    longint unsigned m, idx, fr, ca, cb, g;
    e = 0;
    if (v > 131071) v = 131071;
    if (v * 24389 <= 216 * 65536) return (24389 * v + 28311552 + 1566) / 3132;
    m = v;
    while (m < 16384 && e < 3) begin
      m = m << 3;
      e++;
    end
    idx = (m >> 8) & 511;
    fr = m & 255;
    ca = root_lut[idx];
    cb = root_lut[idx + 1];
    g = ca + (((cb - ca) * fr + 128) >> 8);
    if (e > 0) g = (g + (64'd1 << (e - 1))) >> e;
    return g;
  endfunction

  function longint round_q8(longint v, longint lo, longint hi);
    longint r;
    r = (v + 128) >>> 8;
    return r < lo ? lo : (r > hi ? hi : r);
  endfunction

  function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    longint unsigned lin[3], fv[3], acc, q;
    lab_result_t res;
    lin = '{gamma_lut[red], gamma_lut[green], gamma_lut[blue]};
    for (int i = 0; i < 3; i++) begin
      acc = coef[i][0] * lin[0] + coef[i][1] * lin[1] + coef[i][2] * lin[2];
      q = (acc + (64'd1 << 19)) >> 20;
      if (q > 131071) q = 131071;
      fv[i] = lab_curve(q);
    end
    res.lightness = lab_pkg::L_W'(round_q8(116 * longint'(fv[1]) - 1048576, 0, 25600));
    res.green_red_axis = 16'(round_q8(500 * (longint'(fv[0]) - longint'(fv[1])),
                                      -32768, 32767));
    res.blue_yellow_axis = 16'(round_q8(200 * (longint'(fv[1]) - longint'(fv[2])),
                                        -32768, 32767));
    pending_lab.push_back(res);
  endfunction

  function void check_lab(logic [lab_pkg::L_W-1:0] l, logic [15:0] a, logic [15:0] b);
    lab_result_t exp_lab;
    if (pending_lab.size() == 0) begin
      $error("unexpected result transaction");
      fail_count++;
      return;
    end
    exp_lab = pending_lab.pop_front();
    if (l !== exp_lab.lightness) begin
      $error("lightness expected %0d actual %0d", exp_lab.lightness, l);
      fail_count++;
    end
    if (a !== exp_lab.green_red_axis) begin
      $error("green_red_axis expected %0d actual %0d",
             $signed(exp_lab.green_red_axis), $signed(a));
      fail_count++;
    end
    if (b !== exp_lab.blue_yellow_axis) begin
      $error("blue_yellow_axis expected %0d actual %0d",
             $signed(exp_lab.blue_yellow_axis), $signed(b));
      fail_count++;
    end
  endfunction
endclass

module tb;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  lab_in_if  pix_in();
  lab_out_if lab_out();

  lab_scoreboard lab_sb = new();
  int  idle_cycles = 0;
  int  accepted_pixels = 0;
  bit  hold_done = 1'b0;
  int  ready_mode = 0;

  srgb_to_cielab_d50 u_top (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in.sink),
    .lab_out (lab_out.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    pix_in.valid = 1'b0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    lab_out.ready = 1'b0;
  end

  // Transactions on both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_in.valid && pix_in.ready) begin
        lab_sb.note_pixel(pix_in.red, pix_in.green, pix_in.blue);
        accepted_pixels++;
      end
      if (lab_out.valid && lab_out.ready)
        lab_sb.check_lab(lab_out.lightness, lab_out.green_red_axis, lab_out.blue_yellow_axis);
      if ((pix_in.valid && pix_in.ready) || (lab_out.valid && lab_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // The receiver switches among four ready patterns and holds off once, after 700 pixels have been accepted.
  initial begin : receiver
    int cyc;
    cyc = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 400 == 0) ready_mode = $urandom_range(0, 3);
      if (!hold_done && accepted_pixels >= 700) begin
        lab_out.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      case (ready_mode)
        0: lab_out.ready = 1'b1;
        1: lab_out.ready = ($urandom_range(0, 3) != 0);
        2: lab_out.ready = (cyc % 7 < 3);
        default: lab_out.ready = ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    @(negedge clk);
    pix_in.valid = 1'b1;
    pix_in.red = r;
    pix_in.green = g;
    pix_in.blue = b;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    pix_in.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin : sender
    int burst;
    int r, g, b, kind;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(10, 10, 10);
    send_pixel(11, 11, 11);
    send_pixel(1, 1, 1);
    send_pixel(2, 3, 4);
    send_pixel(20, 20, 20);
    send_pixel(128, 128, 128);
    send_pixel(170, 85, 42);
    send_pixel(0, 0, 10);
    send_pixel(10, 0, 0);
    send_pixel(0, 11, 0);
    send_pixel(254, 1, 254);
    send_pixel(1, 254, 1);
    pause_sender(3);
    burst = 0;
    for (int n = 0; n < 1800; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end else if (kind < 8) begin
        r = $urandom_range(0, 24);
        g = $urandom_range(0, 24);
        b = $urandom_range(0, 24);
      end else begin
        r = $urandom_range(0, 1) * 255;
        g = $urandom_range(0, 1) ? $urandom_range(0, 255) : 255;
        b = $urandom_range(0, 1) * 255;
      end
      send_pixel(r, g, b);
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
      end else begin
        burst--;
      end
    end
    pause_sender(0);
    while (lab_sb.pending_lab.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lab_sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
